// ===== hdl/e2q_pkg.sv =====
// Package for the Euler-angle to quaternion unit: shared widths, codes and helpers.
// Used by the term cell, sine/cosine and top-level modules; depends on nothing else.

package e2q_pkg;

    // Default port widths.
    localparam int ANGLE_BITS_DEF = 16;
    localparam int QUAT_BITS_DEF  = 16;

    // Internal Q2.30 datapath widths.
    localparam int TERM_W = 32;   // one Taylor term, unsigned
    localparam int X2_W   = 32;   // squared half angle, unsigned Q30
    localparam int ACC_W  = 34;   // series accumulator, signed Q30
    localparam int NUM_TERMS = 10;

    // Pi in Q4.60.
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // Fixed result selection for the exact single-axis cases.
    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_X,
        SEL_Y,
        SEL_Z
    } axis_sel_t;

    // Pi rounded to the given number of fraction bits.
    function automatic logic [63:0] pi_code(input int frac);
        logic [63:0] half;
        half = 64'd1 << (59 - frac);
        return (PI_Q60 + half) >> (60 - frac);
    endfunction

    // Magnitude of a signed accumulator value.
    function automatic logic [ACC_W-2:0] acc_mag(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] n;
        n = -v;
        return v[ACC_W-1] ? n[ACC_W-2:0] : v[ACC_W-2:0];
    endfunction

endpackage

// ===== hdl/e2q_term_cell.sv =====
// One Taylor-series cell: multiplies the term by h*h, divides by a fixed factor
// and adds or subtracts the new term. Uses e2q_pkg widths.

module e2q_term_cell #(
    parameter int DIVISOR  = 6,
    parameter bit SUBTRACT = 1'b1
) (
    input  logic                               aclk,
    input  logic                               ce,
    input  logic [e2q_pkg::TERM_W-1:0]         term_in,
    input  logic [e2q_pkg::X2_W-1:0]           x2_in,
    input  logic signed [e2q_pkg::ACC_W-1:0]   acc_in,
    output logic [e2q_pkg::TERM_W-1:0]         term_out,
    output logic [e2q_pkg::X2_W-1:0]           x2_out,
    output logic signed [e2q_pkg::ACC_W-1:0]   acc_out
);

    localparam int PW = e2q_pkg::TERM_W + e2q_pkg::X2_W;
    localparam int NW = 34;
    localparam int RW = 34;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << 33) / DIVISOR);
    localparam logic [NW-1:0] DIV_N = NW'(DIVISOR);

    logic [PW-1:0]                     prod_reg;
    logic [e2q_pkg::X2_W-1:0]          x2_a_reg, x2_b_reg, x2_c_reg;
    logic signed [e2q_pkg::ACC_W-1:0]  acc_a_reg, acc_b_reg, acc_c_reg;
    logic [NW-1:0]                     num_reg;
    logic [NW+RW-1:0]                  recip_prod_reg;
    logic [e2q_pkg::TERM_W-1:0]        term_c_reg;

    logic [PW:0]                       prod_rnd;
    logic [NW-1:0]                     num_next;
    logic [NW-1:0]                     quot_est, quot_fix, rem;
    logic signed [e2q_pkg::ACC_W-1:0]  acc_next;

    // Round the product to Q30 before the reciprocal multiply.
    always_comb begin
        prod_rnd = {1'b0, prod_reg} + (PW+1)'(64'd1 << 29);
        num_next = prod_rnd[NW+29:30];
    end

    // Estimated quotient is at most one short; one compare fixes it.
    always_comb begin
        quot_est = recip_prod_reg[NW+32:33];
        rem      = num_reg - NW'(quot_est * DIV_N);
        quot_fix = (rem >= DIV_N) ? quot_est + NW'(1) : quot_est;
        if (SUBTRACT) begin
            acc_next = acc_b_reg - $signed(e2q_pkg::ACC_W'(quot_fix));
        end else begin
            acc_next = acc_b_reg + $signed(e2q_pkg::ACC_W'(quot_fix));
        end
    end

    // Three register stages per term.
    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg       <= PW'(term_in) * PW'(x2_in);
            x2_a_reg       <= x2_in;
            acc_a_reg      <= acc_in;
            num_reg        <= num_next;
            recip_prod_reg <= (NW+RW)'(num_next) * (NW+RW)'(RECIP);
            x2_b_reg       <= x2_a_reg;
            acc_b_reg      <= acc_a_reg;
            term_c_reg     <= quot_fix[e2q_pkg::TERM_W-1:0];
            x2_c_reg       <= x2_b_reg;
            acc_c_reg      <= acc_next;
        end
    end

    assign term_out = term_c_reg;
    assign x2_out   = x2_c_reg;
    assign acc_out  = acc_c_reg;

endmodule

// ===== hdl/e2q_half_sincos.sv =====
// Sine and cosine of a non-negative Q30 half angle through two chains of term
// cells. Depends on e2q_pkg and e2q_term_cell.

module e2q_half_sincos (
    input  logic                               aclk,
    input  logic                               ce,
    input  logic [e2q_pkg::TERM_W-1:0]         x_in,
    output logic signed [e2q_pkg::ACC_W-1:0]   sin_out,
    output logic signed [e2q_pkg::ACC_W-1:0]   cos_out
);

    localparam int N = e2q_pkg::NUM_TERMS;
    localparam logic [e2q_pkg::TERM_W-1:0] ONE_Q30 = e2q_pkg::TERM_W'(64'd1 << 30);

    logic [2*e2q_pkg::TERM_W-1:0]        sq_reg;
    logic [2*e2q_pkg::TERM_W:0]          sq_rnd;
    logic [e2q_pkg::TERM_W-1:0]          x_a_reg, x_b_reg;
    logic [e2q_pkg::X2_W-1:0]            x2_reg;

    logic [e2q_pkg::TERM_W-1:0]          s_term [N+1];
    logic [e2q_pkg::X2_W-1:0]            s_x2   [N+1];
    logic signed [e2q_pkg::ACC_W-1:0]    s_acc  [N+1];
    logic [e2q_pkg::TERM_W-1:0]          c_term [N+1];
    logic [e2q_pkg::X2_W-1:0]            c_x2   [N+1];
    logic signed [e2q_pkg::ACC_W-1:0]    c_acc  [N+1];

    // Square of the half angle, rounded to Q30.
    assign sq_rnd = {1'b0, sq_reg} + (2*e2q_pkg::TERM_W+1)'(64'd1 << 29);

    always_ff @(posedge aclk) begin
        if (ce) begin
            sq_reg  <= (2*e2q_pkg::TERM_W)'(x_in) * (2*e2q_pkg::TERM_W)'(x_in);
            x_a_reg <= x_in;
            x2_reg  <= sq_rnd[e2q_pkg::X2_W+29:30];
            x_b_reg <= x_a_reg;
        end
    end

    // Seeds: sin starts at h, cos at one.
    assign s_term[0] = x_b_reg;
    assign s_x2[0]   = x2_reg;
    assign s_acc[0]  = $signed(e2q_pkg::ACC_W'(x_b_reg));
    assign c_term[0] = ONE_Q30;
    assign c_x2[0]   = x2_reg;
    assign c_acc[0]  = $signed(e2q_pkg::ACC_W'(ONE_Q30));

    // Two rows of cells, one term per cell.
    for (genvar k = 1; k <= N; k++) begin : g_term
        e2q_term_cell #(
            .DIVISOR  ((2*k) * (2*k + 1)),
            .SUBTRACT ((k % 2) == 1)
        ) u_sin_cell (
            .aclk     (aclk),
            .ce       (ce),
            .term_in  (s_term[k-1]),
            .x2_in    (s_x2[k-1]),
            .acc_in   (s_acc[k-1]),
            .term_out (s_term[k]),
            .x2_out   (s_x2[k]),
            .acc_out  (s_acc[k])
        );
        e2q_term_cell #(
            .DIVISOR  ((2*k - 1) * (2*k)),
            .SUBTRACT ((k % 2) == 1)
        ) u_cos_cell (
            .aclk     (aclk),
            .ce       (ce),
            .term_in  (c_term[k-1]),
            .x2_in    (c_x2[k-1]),
            .acc_in   (c_acc[k-1]),
            .term_out (c_term[k]),
            .x2_out   (c_x2[k]),
            .acc_out  (c_acc[k])
        );
    end

    assign sin_out = s_acc[N];
    assign cos_out = c_acc[N];

endmodule

// ===== hdl/euler_to_quaternion_unit.sv =====
// Top level of the ZYX Euler-angle to unit-quaternion converter.
// Depends on e2q_pkg and e2q_half_sincos.

// Takes one roll/pitch/yaw transaction per clock while the output side does not
// stall and returns one quaternion transaction per input, in order. A result
// passes through the decode, squaring, ten-cell Taylor chain, two-multiply combine
// and output stages. Angles are Q3.(ANGLE_BITS-3) radians saturated to plus or
// minus pi; results are Q2.(QUAT_BITS-2). A single angle of exactly plus pi with
// the other two zero yields the exact axis quaternion. The whole pipeline holds
// while the output transaction waits, so s_tready follows m_tready whenever a
// result is pending.

module euler_to_quaternion_unit #(
    parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF,
    parameter int QUAT_BITS  = e2q_pkg::QUAT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // roll_angle, pitch_angle, yaw_angle from the lowest bit up
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // quat_w, quat_x, quat_y, quat_z from the lowest bit up
    output logic [((4*QUAT_BITS+7)/8)*8-1:0]   m_tdata
);

    localparam int FRAC   = ANGLE_BITS - 3;
    localparam int IN_W   = ((3*ANGLE_BITS+7)/8)*8;
    localparam int OUT_W  = ((4*QUAT_BITS+7)/8)*8;
    localparam int TW     = e2q_pkg::TERM_W;
    localparam int AW     = e2q_pkg::ACC_W;
    localparam int MW     = AW - 1;
    localparam int SC_LAT = 2 + 3 * e2q_pkg::NUM_TERMS;
    localparam int SH     = 32 - QUAT_BITS;
    localparam int SUM_W  = 38;
    localparam logic signed [ANGLE_BITS:0] PI_CODE =
        $signed((ANGLE_BITS+1)'(e2q_pkg::pi_code(FRAC)));
    localparam logic [SUM_W-1:0] RND_ADD = (SH > 0) ? SUM_W'(64'd1 << (SH - 1)) : '0;
    localparam logic [SUM_W-1:0] LIM = SUM_W'(64'd1 << (QUAT_BITS - 2));
    localparam logic [QUAT_BITS-1:0] ONE_Q = QUAT_BITS'(64'd1 << (QUAT_BITS - 2));

    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // ---------------- decode: saturate, halve, classify ----------------
    logic signed [ANGLE_BITS:0] ang_sat [3];
    logic [2:0]                 ang_neg;
    logic [TW-1:0]              ang_x   [3];
    e2q_pkg::axis_sel_t         sel_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ang_sat[i] = $signed({s_tdata[i*ANGLE_BITS + ANGLE_BITS-1],
                                  s_tdata[i*ANGLE_BITS +: ANGLE_BITS]});
            if (ang_sat[i] > PI_CODE) begin
                ang_sat[i] = PI_CODE;
            end else if (ang_sat[i] < -PI_CODE) begin
                ang_sat[i] = -PI_CODE;
            end
            ang_neg[i] = ang_sat[i][ANGLE_BITS];
            ang_x[i]   = TW'(ang_neg[i] ? -ang_sat[i] : ang_sat[i]) << (29 - FRAC);
        end
        sel_next = e2q_pkg::SEL_NONE;
        if (ang_sat[0] == PI_CODE && ang_sat[1] == 0 && ang_sat[2] == 0) begin
            sel_next = e2q_pkg::SEL_X;
        end else if (ang_sat[1] == PI_CODE && ang_sat[0] == 0 && ang_sat[2] == 0) begin
            sel_next = e2q_pkg::SEL_Y;
        end else if (ang_sat[2] == PI_CODE && ang_sat[0] == 0 && ang_sat[1] == 0) begin
            sel_next = e2q_pkg::SEL_Z;
        end
    end

    logic [TW-1:0]      dec_x_reg [3];
    logic [2:0]         dec_neg_reg;
    e2q_pkg::axis_sel_t dec_sel_reg;
    logic               dec_vld_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            dec_x_reg   <= ang_x;
            dec_neg_reg <= ang_neg;
            dec_sel_reg <= sel_next;
        end
    end

    // ---------------- sine and cosine of the three half angles ----------------
    logic signed [AW-1:0] sin_raw [3];
    logic signed [AW-1:0] cos_raw [3];

    for (genvar i = 0; i < 3; i++) begin : g_sc
        e2q_half_sincos u_sincos (
            .aclk    (aclk),
            .ce      (ce),
            .x_in    (dec_x_reg[i]),
            .sin_out (sin_raw[i]),
            .cos_out (cos_raw[i])
        );
    end

    // Side-band delay matching the sine/cosine chains.
    logic [2:0]         neg_dly_reg [SC_LAT];
    e2q_pkg::axis_sel_t sel_dly_reg [SC_LAT];
    logic [SC_LAT-1:0]  vld_dly_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            neg_dly_reg[0] <= dec_neg_reg;
            sel_dly_reg[0] <= dec_sel_reg;
            for (int j = 1; j < SC_LAT; j++) begin
                neg_dly_reg[j] <= neg_dly_reg[j-1];
                sel_dly_reg[j] <= sel_dly_reg[j-1];
            end
        end
    end

    // ---------------- first products ----------------
    logic signed [AW-1:0] sv [3];
    logic [MW-1:0]        s_mag [3];
    logic [MW-1:0]        c_mag [3];
    logic [2:0]           s_sgn, c_sgn;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sv[i]    = neg_dly_reg[SC_LAT-1][i] ? -sin_raw[i] : sin_raw[i];
            s_mag[i] = e2q_pkg::acc_mag(sv[i]);
            s_sgn[i] = sv[i][AW-1];
            c_mag[i] = e2q_pkg::acc_mag(cos_raw[i]);
            c_sgn[i] = cos_raw[i][AW-1];
        end
    end

    // Pair order: cr*cp, sr*sp, sr*cp, cr*sp.
    logic [2*MW-1:0]    p1_reg  [4];
    logic [3:0]         p1_sgn_reg;
    logic [MW-1:0]      cy_mag_reg, sy_mag_reg;
    logic               cy_sgn_reg, sy_sgn_reg;
    e2q_pkg::axis_sel_t m1_sel_reg;
    logic               m1_vld_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p1_reg[0]  <= (2*MW)'(c_mag[0]) * (2*MW)'(c_mag[1]);
            p1_reg[1]  <= (2*MW)'(s_mag[0]) * (2*MW)'(s_mag[1]);
            p1_reg[2]  <= (2*MW)'(s_mag[0]) * (2*MW)'(c_mag[1]);
            p1_reg[3]  <= (2*MW)'(c_mag[0]) * (2*MW)'(s_mag[1]);
            p1_sgn_reg <= {c_sgn[0] ^ s_sgn[1], s_sgn[0] ^ c_sgn[1],
                           s_sgn[0] ^ s_sgn[1], c_sgn[0] ^ c_sgn[1]};
            cy_mag_reg <= c_mag[2];
            sy_mag_reg <= s_mag[2];
            cy_sgn_reg <= c_sgn[2];
            sy_sgn_reg <= s_sgn[2];
            m1_sel_reg <= sel_dly_reg[SC_LAT-1];
        end
    end

    // ---------------- second products ----------------
    localparam int P1R_W = 2*MW - 30 + 1;
    localparam int P2_W  = P1R_W + MW;
    logic [2*MW:0]    p1_sum [4];
    logic [P1R_W-1:0] p1_rnd [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            p1_sum[i] = {1'b0, p1_reg[i]} + (2*MW+1)'(64'd1 << 29);
            p1_rnd[i] = p1_sum[i][2*MW:30];
        end
    end

    // Order: w(a,b), x(a,b), y(a,b), z(a,b).
    logic [P2_W-1:0]    p2_reg [8];
    logic [7:0]         p2_sgn_reg;
    e2q_pkg::axis_sel_t m2_sel_reg;
    logic               m2_vld_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p2_reg[0]  <= P2_W'(p1_rnd[0]) * P2_W'(cy_mag_reg);
            p2_reg[1]  <= P2_W'(p1_rnd[1]) * P2_W'(sy_mag_reg);
            p2_reg[2]  <= P2_W'(p1_rnd[2]) * P2_W'(cy_mag_reg);
            p2_reg[3]  <= P2_W'(p1_rnd[3]) * P2_W'(sy_mag_reg);
            p2_reg[4]  <= P2_W'(p1_rnd[3]) * P2_W'(cy_mag_reg);
            p2_reg[5]  <= P2_W'(p1_rnd[2]) * P2_W'(sy_mag_reg);
            p2_reg[6]  <= P2_W'(p1_rnd[0]) * P2_W'(sy_mag_reg);
            p2_reg[7]  <= P2_W'(p1_rnd[1]) * P2_W'(cy_mag_reg);
            p2_sgn_reg <= {p1_sgn_reg[1] ^ cy_sgn_reg, p1_sgn_reg[0] ^ sy_sgn_reg,
                           p1_sgn_reg[2] ^ sy_sgn_reg, p1_sgn_reg[3] ^ cy_sgn_reg,
                           p1_sgn_reg[3] ^ sy_sgn_reg, p1_sgn_reg[2] ^ cy_sgn_reg,
                           p1_sgn_reg[1] ^ sy_sgn_reg, p1_sgn_reg[0] ^ cy_sgn_reg};
            m2_sel_reg <= m1_sel_reg;
        end
    end

    // ---------------- round, sign and sum ----------------
    logic [P2_W:0]             p2_sum [8];
    logic signed [SUM_W-1:0]   p2_val [8];
    logic signed [SUM_W-1:0]   part_next [4];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            p2_sum[i] = {1'b0, p2_reg[i]} + (P2_W+1)'(64'd1 << 29);
            p2_val[i] = $signed(SUM_W'(p2_sum[i][P2_W:30]));
            if (p2_sgn_reg[i]) begin
                p2_val[i] = -p2_val[i];
            end
        end
        part_next[0] = p2_val[0] + p2_val[1];
        part_next[1] = p2_val[2] - p2_val[3];
        part_next[2] = p2_val[4] + p2_val[5];
        part_next[3] = p2_val[6] - p2_val[7];
    end

    logic signed [SUM_W-1:0] part_reg [4];
    e2q_pkg::axis_sel_t      m3_sel_reg;
    logic                    m3_vld_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            part_reg   <= part_next;
            m3_sel_reg <= m2_sel_reg;
        end
    end

    // ---------------- output scaling, saturation and axis cases ----------------
    logic [SUM_W-1:0]     enc_mag [4];
    logic [QUAT_BITS-1:0] enc_val [4];
    logic [OUT_W-1:0]     out_next;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            enc_mag[i] = part_reg[i][SUM_W-1] ? SUM_W'(-part_reg[i]) : SUM_W'(part_reg[i]);
            enc_mag[i] = (enc_mag[i] + RND_ADD) >> SH;
            if (enc_mag[i] > LIM) begin
                enc_mag[i] = LIM;
            end
            enc_val[i] = part_reg[i][SUM_W-1] ? QUAT_BITS'(-enc_mag[i])
                                              : QUAT_BITS'(enc_mag[i]);
        end
        unique case (m3_sel_reg)
            e2q_pkg::SEL_X: begin
                enc_val = '{'0, ONE_Q, '0, '0};
            end
            e2q_pkg::SEL_Y: begin
                enc_val = '{'0, '0, ONE_Q, '0};
            end
            e2q_pkg::SEL_Z: begin
                enc_val = '{'0, '0, '0, ONE_Q};
            end
            default: begin
            end
        endcase
        out_next = '0;
        for (int i = 0; i < 4; i++) begin
            out_next[i*QUAT_BITS +: QUAT_BITS] = enc_val[i];
        end
    end

    logic [OUT_W-1:0] out_data_reg;
    logic             out_vld_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_data_reg <= out_next;
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_vld_reg <= 1'b0;
            vld_dly_reg <= '0;
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            m3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            dec_vld_reg <= s_tvalid;
            vld_dly_reg <= {vld_dly_reg[SC_LAT-2:0], dec_vld_reg};
            m1_vld_reg  <= vld_dly_reg[SC_LAT-1];
            m2_vld_reg  <= m1_vld_reg;
            m3_vld_reg  <= m2_vld_reg;
            out_vld_reg <= m3_vld_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    logic unused_in;
    assign unused_in = ^s_tdata[IN_W-1:3*ANGLE_BITS-1];

endmodule

// ===== hdl/e2q_checker.sv =====
// Port-level checks for euler_to_quaternion_unit, with the bind that attaches them.
// Depends on the top level's ports only.

module e2q_checker #(
    parameter int ANGLE_BITS = 16,
    parameter int QUAT_BITS  = 16
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((4*QUAT_BITS+7)/8)*8-1:0]  m_tdata
);

    localparam logic [QUAT_BITS-1:0] MOST_NEG = {1'b1, {(QUAT_BITS-1){1'b0}}};

    // A stalled result transaction holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Input is taken whenever the output side can move.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output side");

    // Nothing comes out right after reset.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // No part ever reaches the most negative code.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[QUAT_BITS-1:0] != MOST_NEG)
                  && (m_tdata[2*QUAT_BITS-1:QUAT_BITS] != MOST_NEG)
                  && (m_tdata[3*QUAT_BITS-1:2*QUAT_BITS] != MOST_NEG)
                  && (m_tdata[4*QUAT_BITS-1:3*QUAT_BITS] != MOST_NEG))
        else $error("quaternion part out of range");

    logic unused_in;
    assign unused_in = s_tvalid ^ (^s_tdata);

endmodule

bind euler_to_quaternion_unit e2q_checker #(
    .ANGLE_BITS (ANGLE_BITS),
    .QUAT_BITS  (QUAT_BITS)
) u_e2q_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/e2q_scoreboard.sv =====
// Checker for the Euler-angle to quaternion unit: watches both stream channels,
// predicts each quaternion from the accepted angles and compares. Needs e2q_pkg.
`timescale 1ns / 1ps

module e2q_scoreboard (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    localparam int FRAC_IN = 13;

    logic [63:0] quat_queue[$];

    // Pi code at the input scale, computed independently of the package helper.
    function automatic longint angle_pi();
        logic [63:0] q;
        q = (e2q_pkg::PI_Q60 + (64'd1 << (59 - FRAC_IN))) >> (60 - FRAC_IN);
        return longint'(q);
    endfunction

    // Sign-extend a 16-bit angle and limit it to plus or minus pi.
    function automatic longint clamp_angle(input logic [15:0] raw);
        longint a;
        longint p;
        a = longint'($signed(raw));
        p = angle_pi();
        if (a > p) a = p;
        if (a < -p) a = -p;
        return a;
    endfunction

    function automatic longint round_q30(input longint unsigned a, input longint unsigned b);
        return longint'((a * b + (64'd1 << 29)) >> 30);
    endfunction

    // Signed Q30 product, formed on magnitudes and rounded half up.
    function automatic longint mult_q30(input longint a, input longint b);
        longint p;
        p = round_q30(a < 0 ? -a : a, b < 0 ? -b : b);
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    // Sine and cosine of a half angle from the leading term plus ten further Taylor terms each.
    function automatic void half_angle_trig(input longint a, output longint sn,
                                            output longint cs);
        longint unsigned h, h2, ts, tc;
        longint s, c;
        h = longint'(a < 0 ? -a : a) << (29 - FRAC_IN);
        h2 = round_q30(h, h);
        ts = h;
        tc = 64'd1 << 30;
        s = h;
        c = 64'd1 << 30;
        for (int k = 1; k <= 10; k++) begin
            ts = round_q30(ts, h2) / longint'((2 * k) * (2 * k + 1));
            tc = round_q30(tc, h2) / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                s -= ts;
                c -= tc;
            end else begin
                s += ts;
                c += tc;
            end
        end
        sn = (a < 0) ? -s : s;
        cs = c;
    endfunction

    // Round a Q30 part half away from zero to Q2.14 and limit to unit.
    function automatic logic [15:0] to_q14(input longint v);
        longint unsigned m;
        m = v < 0 ? -v : v;
        m = (m + (64'd1 << 15)) >> 16;
        if (m > 16384) m = 16384;
        return v < 0 ? 16'(-m) : 16'(m);
    endfunction

    // Full prediction of one quaternion transaction.
    function automatic logic [63:0] predict_quat(input logic [47:0] angles);
        longint r, p, y, pc, sr, cr, sp, cp, sy, cy, w, x, yy, z;
        r = clamp_angle(angles[15:0]);
        p = clamp_angle(angles[31:16]);
        y = clamp_angle(angles[47:32]);
        pc = angle_pi();
        // Exact axis quaternions for a lone angle of plus pi.
        if (r == pc && p == 0 && y == 0) return {16'd0, 16'd0, 16'd16384, 16'd0};
        if (p == pc && r == 0 && y == 0) return {16'd0, 16'd16384, 16'd0, 16'd0};
        if (y == pc && r == 0 && p == 0) return {16'd16384, 16'd0, 16'd0, 16'd0};
        half_angle_trig(r, sr, cr);
        half_angle_trig(p, sp, cp);
        half_angle_trig(y, sy, cy);
        w  = mult_q30(mult_q30(cr, cp), cy) + mult_q30(mult_q30(sr, sp), sy);
        x  = mult_q30(mult_q30(sr, cp), cy) - mult_q30(mult_q30(cr, sp), sy);
        yy = mult_q30(mult_q30(cr, sp), cy) + mult_q30(mult_q30(sr, cp), sy);
        z  = mult_q30(mult_q30(cr, cp), sy) - mult_q30(mult_q30(sr, sp), cy);
        return {to_q14(z), to_q14(yy), to_q14(x), to_q14(w)};
    endfunction

    assign pending = quat_queue.size();

    // Record expectations and compare results at each accepted transaction.
    always @(posedge aclk) begin
        logic [63:0] want;
        if (!aresetn) begin
            fail_count <= 0;
            checked <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (quat_queue.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("mismatch: result %h with nothing expected", m_tdata);
                end else begin
                    want = quat_queue.pop_front();
                    checked <= checked + 1;
                    if (want !== m_tdata) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: w/x/y/z expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                                $signed(want[15:0]), $signed(want[31:16]),
                                $signed(want[47:32]), $signed(want[63:48]),
                                $signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
                                $signed(m_tdata[47:32]), $signed(m_tdata[63:48]));
                    end
                end
            end
            if (s_tvalid && s_tready)
                quat_queue.push_back(predict_quat(s_tdata));
        end
    end

endmodule

// ===== dv/euler_to_quaternion_unit_tb.sv =====
// Testbench top for euler_to_quaternion_unit: drives angle transactions under
// several idling phases and gives the verdict. Needs e2q_pkg and e2q_scoreboard.
`timescale 1ns / 1ps

module euler_to_quaternion_unit_tb;

    localparam int PI_CODE = 25736;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    int          fail_count, pending, checked;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    int          cycle_count = 0;

    always #5 aclk = ~aclk;

    euler_to_quaternion_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    e2q_scoreboard checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    // Receiver: random stalls, or a long hold-off counted here.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Timeout watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Mostly in-range angles, with some codes beyond pi and a few small ones.
    function automatic logic [15:0] rand_angle();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'($urandom_range(40));
            2: return 16'(-$urandom_range(40));
            default: return 16'($urandom_range(2 * PI_CODE) - PI_CODE);
        endcase
    endfunction

    // Offer one transaction and wait until it is accepted. Valid stays high
    // after acceptance so that the next transaction can follow directly.
    task automatic send_angles(input logic [15:0] r, input logic [15:0] p,
                               input logic [15:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, p, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] edge_vals[8];
        edge_vals = '{16'd0, 16'(PI_CODE), 16'(-PI_CODE), 16'h7FFF,
                      16'h8000, 16'd1, 16'hFFFF, 16'(PI_CODE + 1)};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: lone plus pi on each axis, negative pi, saturation, extremes.
        send_angles(16'(PI_CODE), 16'd0, 16'd0);
        send_angles(16'd0, 16'(PI_CODE), 16'd0);
        send_angles(16'd0, 16'd0, 16'(PI_CODE));
        send_angles(16'h7FFF, 16'd0, 16'd0);
        send_angles(16'd0, 16'h7FFF, 16'd0);
        send_angles(16'd0, 16'd0, 16'h7FFF);
        send_angles(16'(-PI_CODE), 16'd0, 16'd0);
        send_angles(16'd0, 16'h8000, 16'd0);
        for (int i = 0; i < 8; i++)
            send_angles(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8]);
        send_angles(16'(PI_CODE), 16'(PI_CODE), 16'(PI_CODE));
        send_angles(16'h5555, 16'hAAAA, 16'h1234);

        // Long receiver hold-off while the sender keeps offering.
        hold_cycles = 120;
        for (int i = 0; i < 60; i++) send_angles(rand_angle(), rand_angle(), rand_angle());

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 34 : 80) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 34 : 80) : 0;
            for (int i = 0; i < RANDOM_ITEMS / 4; i++)
                send_angles(rand_angle(), rand_angle(), rand_angle());
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Covered %0d quaternion results: axis cases, saturation and random angles",
                 checked);
        $display("under free running, sender gaps, receiver stalls and a long hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/e2q_pkg.sv
hdl/e2q_term_cell.sv
hdl/e2q_half_sincos.sv
hdl/euler_to_quaternion_unit.sv
hdl/e2q_checker.sv
dv/e2q_scoreboard.sv
dv/euler_to_quaternion_unit_tb.sv
